/* rtl/assert_macros.svh */
// Assertion macros shared by the pressure compensation RTL.
// Every assertion samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

/* rtl/bpc_pkg.sv */
// Shared types, constants and helpers for the pressure compensation pipeline.
// No dependencies.
`default_nettype none
package bpc_pkg;

    localparam int DIV_W = 32;

    // configuration register indexes
    localparam logic [2:0] CFG_AC123 = 3'd0;
    localparam logic [2:0] CFG_AC456 = 3'd1;
    localparam logic [2:0] CFG_B12   = 3'd2;
    localparam logic [2:0] CFG_MCMD  = 3'd3;
    localparam logic [2:0] CFG_OSS   = 3'd4;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_K1       = 32'd3038;
    localparam logic [31:0] C_K2       = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_K3       = 32'd3791;
    localparam logic [31:0] C_P_SCALE  = 32'd50000;
    localparam logic [31:0] C_B4_OFS   = 32'd32768;
    localparam logic [31:0] C_MSB      = 32'h8000_0000;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [18:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               div_error;
    } t_out;

    // calibration words, sign or zero extended to 32 bits
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [1:0]  oss;
    } t_coef;

    // sideband through the temperature divider
    typedef struct packed {
        logic [31:0] x1;
        logic        neg;
        logic        zero;
        logic [18:0] up;
    } t_tside;

    // sideband through the pressure divider
    typedef struct packed {
        logic [31:0] t;
        logic        zero;
        logic        big;
    } t_pside;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/bpc_div.sv */
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Uses bpc_pkg; sideband rides along with each transaction.
`default_nettype none
module bpc_div #(
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_dividend,
    input  wire logic [31:0]       i_divisor,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [31:0]            o_quot,
    output logic [SIDE_W-1:0]      o_side
);
    import bpc_pkg::*;
    `include "assert_macros.svh"

    logic [DIV_W-1:0]  r_vld;
    logic [31:0]       r_rem  [DIV_W];
    logic [31:0]       r_num  [DIV_W];
    logic [31:0]       r_den  [DIV_W];
    logic [31:0]       r_quo  [DIV_W];
    logic [SIDE_W-1:0] r_side [DIV_W];

    genvar k;
    generate
        for (k = 0; k < DIV_W; k++) begin : g_stage
            logic [31:0]       s_rem, s_num, s_den, s_quo;
            logic [SIDE_W-1:0] s_side;
            logic              s_vld;
            logic [32:0]       n_trial;
            logic [32:0]       n_diff;
            logic [31:0]       n_rem;
            logic              n_bit;

            if (k == 0) begin : g_first
                assign s_vld  = i_valid;
                assign s_rem  = '0;
                assign s_num  = i_dividend;
                assign s_den  = i_divisor;
                assign s_quo  = '0;
                assign s_side = i_side;
            end else begin : g_next
                assign s_vld  = r_vld[k-1];
                assign s_rem  = r_rem[k-1];
                assign s_num  = r_num[k-1];
                assign s_den  = r_den[k-1];
                assign s_quo  = r_quo[k-1];
                assign s_side = r_side[k-1];
            end

            always_comb begin
                n_trial = {s_rem, s_num[31]};
                n_diff  = n_trial - {1'b0, s_den};
                n_bit   = !n_diff[32];
                n_rem   = n_bit ? n_diff[31:0] : n_trial[31:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= s_vld;
                end
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_num[k]  <= {s_num[30:0], 1'b0};
                    r_den[k]  <= s_den;
                    r_quo[k]  <= {s_quo[30:0], n_bit};
                    r_side[k] <= s_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[DIV_W-1];
    assign o_quot  = r_quo[DIV_W-1];
    assign o_side  = r_side[DIV_W-1];

    // a held pipeline keeps every valid bit in place
    `ASSERT_CLK(a_div_hold, !i_en |=> $stable(r_vld), "divider valid bits moved while held")
    `ASSERT_CLK(a_div_shift, i_en |=> r_vld[DIV_W-1] == $past(r_vld[DIV_W-2]),
        "divider valid bit skipped a stage")

endmodule
`default_nettype wire

/* rtl/bpc_press.sv */
// Pressure terms between the two dividers: B5, temperature, B3, B4, B7.
// Uses bpc_pkg; eight register stages, all held by i_en.
`default_nettype none
module bpc_press (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire bpc_pkg::t_coef  i_coef,
    input  wire logic            i_valid,
    input  wire logic [31:0]     i_quot,
    input  wire bpc_pkg::t_tside i_side,
    output logic                 o_valid,
    output logic [31:0]          o_dividend,
    output logic [31:0]          o_divisor,
    output bpc_pkg::t_pside      o_side
);
    import bpc_pkg::*;

    logic [7:0]  r_vld;
    logic [31:0] r3_t, r3_b6;
    logic [31:0] r4_t, r4_sqm, r4_m2, r4_m3;
    logic [31:0] r5_t, r5_sq, r5_x2a, r5_x1c;
    logic [31:0] r6_t, r6_mb2, r6_mb1, r6_x2a, r6_x1c;
    logic [31:0] r7_t, r7_b3, r7_y;
    logic [31:0] r8_t, r8_b4m, r8_dd;
    logic [31:0] r9_t, r9_b4, r9_b7;
    logic [6:0]  r_zero;
    logic [18:0] r3_up, r4_up, r5_up, r6_up, r7_up;
    logic [31:0] r_dividend, r_divisor;
    t_pside      r_side;

    logic [31:0] n_q, n_b5, n_x1, n_x3, n_x3b, n_b3, n_b4;

    always_comb begin
        n_q   = i_side.neg ? 32'(-i_quot) : i_quot;
        n_b5  = i_side.x1 + n_q;
        n_x1  = asr32(r6_mb2, 5'd11);
        n_x3  = n_x1 + r6_x2a;
        n_b3  = asr32((((i_coef.ac1 << 2) + n_x3) << i_coef.oss) + 32'd2, 5'd2);
        n_x3b = asr32(r6_x1c + asr32(r6_mb1, 5'd16) + 32'd2, 5'd2);
        n_b4  = r8_b4m >> 15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
        if (i_en) begin
            // B5, temperature and B6
            r3_t  <= asr32(n_b5 + 32'd8, 5'd4);
            r3_b6 <= n_b5 - C_B6_OFS;
            r3_up <= i_side.up;
            r_zero[0] <= i_side.zero;
            // products of B6
            r4_t   <= r3_t;
            r4_sqm <= mul32(r3_b6, r3_b6);
            r4_m2  <= mul32(i_coef.ac2, r3_b6);
            r4_m3  <= mul32(i_coef.ac3, r3_b6);
            r4_up  <= r3_up;
            r_zero[1] <= r_zero[0];
            r5_t   <= r4_t;
            r5_sq  <= asr32(r4_sqm, 5'd12);
            r5_x2a <= asr32(r4_m2, 5'd11);
            r5_x1c <= asr32(r4_m3, 5'd13);
            r5_up  <= r4_up;
            r_zero[2] <= r_zero[1];
            r6_t   <= r5_t;
            r6_mb2 <= mul32(i_coef.b2, r5_sq);
            r6_mb1 <= mul32(i_coef.b1, r5_sq);
            r6_x2a <= r5_x2a;
            r6_x1c <= r5_x1c;
            r6_up  <= r5_up;
            r_zero[3] <= r_zero[2];
            // B3 and the B4 operand
            r7_t  <= r6_t;
            r7_b3 <= n_b3;
            r7_y  <= n_x3b + C_B4_OFS;
            r7_up <= r6_up;
            r_zero[4] <= r_zero[3];
            r8_t   <= r7_t;
            r8_b4m <= mul32(i_coef.ac4, r7_y);
            r8_dd  <= {13'd0, r7_up} - r7_b3;
            r_zero[5] <= r_zero[4];
            r9_t  <= r8_t;
            r9_b4 <= n_b4;
            r9_b7 <= mul32(r8_dd, C_P_SCALE >> i_coef.oss);
            r_zero[6] <= r_zero[5] | (n_b4 == '0);
            // choose the unsigned division form by the top bit of B7
            r_side.t    <= r9_t;
            r_side.zero <= r_zero[6];
            r_side.big  <= (r9_b7 & C_MSB) != '0;
            r_dividend  <= ((r9_b7 & C_MSB) != '0) ? r9_b7 : (r9_b7 << 1);
            r_divisor   <= r9_b4;
        end
    end

    assign o_valid    = r_vld[7];
    assign o_dividend = r_dividend;
    assign o_divisor  = r_divisor;
    assign o_side     = r_side;

endmodule
`default_nettype wire

/* rtl/barometric_pressure_compensation.sv */
// Throughput: one transaction per cycle while the output is not stalled; the two
// 32-stage bit-per-stage dividers hold most of the pipeline registers.
// A stalled output holds the whole pipeline in place; nothing is dropped.
// Reset (synchronous, active low) clears all valid bits and the calibration
// registers to zero.
`default_nettype none
module barometric_pressure_compensation (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bpc_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output bpc_pkg::t_out      o_out,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [47:0]   i_cfg_data
);
    import bpc_pkg::*;
    `include "assert_macros.svh"

    logic [47:0] r_coef_a, r_coef_b;
    logic [31:0] r_coef_c, r_coef_d;
    logic [1:0]  r_oss;
    t_coef       s_coef;
    logic [31:0] s_mc, s_md;
    logic        s_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= '0;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_coef_d <= '0;
            r_oss    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AC123: r_coef_a <= i_cfg_data;
                CFG_AC456: r_coef_b <= i_cfg_data;
                CFG_B12:   r_coef_c <= i_cfg_data[31:0];
                CFG_MCMD:  r_coef_d <= i_cfg_data[31:0];
                CFG_OSS:   r_oss    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_coef.ac1 = {{16{r_coef_a[15]}}, r_coef_a[15:0]};
        s_coef.ac2 = {{16{r_coef_a[31]}}, r_coef_a[31:16]};
        s_coef.ac3 = {{16{r_coef_a[47]}}, r_coef_a[47:32]};
        s_coef.ac4 = {16'd0, r_coef_b[15:0]};
        s_coef.b1  = {{16{r_coef_c[15]}}, r_coef_c[15:0]};
        s_coef.b2  = {{16{r_coef_c[31]}}, r_coef_c[31:16]};
        s_coef.oss = r_oss;
        s_mc = {{16{r_coef_d[15]}}, r_coef_d[15:0]};
        s_md = {{16{r_coef_d[31]}}, r_coef_d[31:16]};
    end

    // the whole pipeline advances unless a finished result is stalled
    assign s_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !s_en;

    // front: X1 and the temperature divider operands
    logic        r1_vld, r2_vld;
    logic [31:0] r1_m;
    logic [18:0] r1_up;
    logic [31:0] r2_num, r2_den;
    t_tside      r2_side;
    logic [31:0] n_x1, n_den, n_a;

    always_comb begin
        n_x1  = asr32(r1_m, 5'd15);
        n_den = n_x1 + s_md;
        n_a   = s_mc << 11;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (s_en) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
        end
        if (s_en) begin
            r1_m  <= mul32({16'd0, i_in.raw_temp} - {16'd0, r_coef_b[47:32]},
                           {16'd0, r_coef_b[31:16]});
            r1_up <= i_in.raw_pressure;
            r2_num <= n_a[31] ? 32'(-n_a) : n_a;
            r2_den <= n_den[31] ? 32'(-n_den) : n_den;
            r2_side.x1   <= n_x1;
            r2_side.neg  <= n_a[31] ^ n_den[31];
            r2_side.zero <= n_den == '0;
            r2_side.up   <= r1_up;
        end
    end

    logic              s_td_vld;
    logic [31:0]       s_td_q;
    logic [$bits(t_tside)-1:0] s_td_side;
    t_tside            s_td_side_t;

    bpc_div #(.SIDE_W($bits(t_tside))) u_tdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (s_en),
        .i_valid    (r2_vld),
        .i_dividend (r2_num),
        .i_divisor  (r2_den),
        .i_side     (r2_side),
        .o_valid    (s_td_vld),
        .o_quot     (s_td_q),
        .o_side     (s_td_side)
    );
    assign s_td_side_t = t_tside'(s_td_side);

    logic        s_pc_vld;
    logic [31:0] s_pc_num, s_pc_den;
    t_pside      s_pc_side;

    bpc_press u_press (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (s_en),
        .i_coef     (s_coef),
        .i_valid    (s_td_vld),
        .i_quot     (s_td_q),
        .i_side     (s_td_side_t),
        .o_valid    (s_pc_vld),
        .o_dividend (s_pc_num),
        .o_divisor  (s_pc_den),
        .o_side     (s_pc_side)
    );

    logic              s_pd_vld;
    logic [31:0]       s_pd_q;
    logic [$bits(t_pside)-1:0] s_pd_side;
    t_pside            s_pd_side_t;

    bpc_div #(.SIDE_W($bits(t_pside))) u_pdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (s_en),
        .i_valid    (s_pc_vld),
        .i_dividend (s_pc_num),
        .i_divisor  (s_pc_den),
        .i_side     (s_pc_side),
        .o_valid    (s_pd_vld),
        .o_quot     (s_pd_q),
        .o_side     (s_pd_side)
    );
    assign s_pd_side_t = t_pside'(s_pd_side);

    // tail: final polynomial correction
    logic [2:0]  r_tvld;
    logic [31:0] r11_p, r11_s, r12_p, r12_m1, r12_m2, r13_p, r13_m3, r13_m2;
    logic [31:0] r11_t, r12_t, r13_t;
    logic [2:0]  r_tzero;
    logic        r_out_vld;
    t_out        r_out;
    logic [31:0] n_p, n_pf;

    always_comb begin
        n_p  = s_pd_side_t.big ? (s_pd_q << 1) : s_pd_q;
        n_pf = r13_p + asr32(asr32(r13_m3, 5'd16) + asr32(r13_m2, 5'd16) + C_K3, 5'd4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld    <= '0;
            r_out_vld <= 1'b0;
        end else if (s_en) begin
            r_tvld    <= {r_tvld[1:0], s_pd_vld};
            r_out_vld <= r_tvld[2];
        end
        if (s_en) begin
            r11_p  <= n_p;
            r11_s  <= asr32(n_p, 5'd8);
            r11_t  <= s_pd_side_t.t;
            r_tzero[0] <= s_pd_side_t.zero;
            r12_p  <= r11_p;
            r12_m1 <= mul32(r11_s, r11_s);
            r12_m2 <= mul32(C_K2, r11_p);
            r12_t  <= r11_t;
            r_tzero[1] <= r_tzero[0];
            r13_p  <= r12_p;
            r13_m3 <= mul32(r12_m1, C_K1);
            r13_m2 <= r12_m2;
            r13_t  <= r12_t;
            r_tzero[2] <= r_tzero[1];
            // zero results on a zero divisor
            r_out.temperature_tenths <= r_tzero[2] ? '0 : $signed(r13_t);
            r_out.pressure_pa        <= r_tzero[2] ? '0 : $signed(n_pf);
            r_out.div_error          <= r_tzero[2];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `ASSERT_CLK(a_err_zero, o_out_valid && o_out.div_error |->
        o_out.temperature_tenths == 0 && o_out.pressure_pa == 0,
        "error result carries nonzero fields")
    `ASSERT_NEVER(a_stall_cause, o_in_stall && !(o_out_valid && i_out_stall),
        "input stalled without a stalled output")
    `ASSERT_CLK(a_tail_flow, s_en |=> r_out_vld == $past(r_tvld[2]),
        "tail valid bit skipped a stage")

endmodule
`default_nettype wire

/* test/barometric_pressure_compensation_tb.sv */
// Self-checking bench for barometric_pressure_compensation: directed and random
// samples under several calibration sets, checked against an internal predictor.
// Depends on bpc_pkg and the RTL top level.
`default_nettype none
module barometric_pressure_compensation_tb;
    import bpc_pkg::*;

    localparam int LATENCY    = 78;
    localparam int N_RANDOM   = 250;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    t_in           i_in;
    logic          o_out_valid;
    logic          i_out_stall;
    t_out          o_out;
    logic          i_cfg_we;
    logic [2:0]    i_cfg_idx;
    logic [47:0]   i_cfg_data;

    barometric_pressure_compensation uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor copy of the calibration
    logic [47:0] cal_ac123, cal_ac456;
    logic [31:0] cal_b12, cal_mcmd;
    logic [1:0]  cal_oss;

    t_in  pending_samples[$];
    t_out expected_readings[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   hold_count = 0;
    bit   no_idle;       // suppress random idling on both sides
    bit   hold_output;   // long receiver hold-off
    bit   pause_input;   // sender waits for drain

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] ashr(input logic [31:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_out compensate(input t_in s);
        t_out r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, p, t;
        ac1 = sx16(cal_ac123[15:0]);
        ac2 = sx16(cal_ac123[31:16]);
        ac3 = sx16(cal_ac123[47:32]);
        ac4 = {16'd0, cal_ac456[15:0]};
        ac5 = {16'd0, cal_ac456[31:16]};
        ac6 = {16'd0, cal_ac456[47:32]};
        b1 = sx16(cal_b12[15:0]);
        b2 = sx16(cal_b12[31:16]);
        mc = sx16(cal_mcmd[15:0]);
        md = sx16(cal_mcmd[31:16]);
        r = '0;
        r.div_error = 1'b1;
        x1 = ashr(({16'd0, s.raw_temp} - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = sdiv(mc << 11, den);
        b5 = x1 + x2;
        t = ashr(b5 + 8, 4);
        b6 = b5 - C_B6_OFS;
        sq = ashr(b6 * b6, 12);
        x1 = ashr(b2 * sq, 11);
        x2 = ashr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = ashr((((ac1 << 2) + x3) << cal_oss) + 2, 2);
        x1 = ashr(ac3 * b6, 13);
        x2 = ashr(b1 * sq, 16);
        x3 = ashr(x1 + x2 + 2, 2);
        b4 = (ac4 * (x3 + C_B4_OFS)) >> 15;
        if (b4 == 0) return r;
        b7 = ({13'd0, s.raw_pressure} - b3) * (C_P_SCALE >> cal_oss);
        if (b7 < C_MSB) p = (b7 << 1) / b4;
        else            p = (b7 / b4) << 1;
        x1 = ashr(p, 8) * ashr(p, 8);
        x1 = ashr(x1 * C_K1, 16);
        x2 = ashr(C_K2 * p, 16);
        p = p + ashr(x1 + x2 + C_K3, 4);
        r.temperature_tenths = t;
        r.pressure_pa = p;
        r.div_error = 1'b0;
        return r;
    endfunction

    // driver: offer the head of the queue, keep it steady while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_readings.push_back(compensate(i_in));
                void'(pending_samples.pop_front());
            end
            if (i_in_valid && o_in_stall) begin
                // hold
            end else if (pending_samples.size() > 0 && !pause_input &&
                         (no_idle || $urandom_range(99) >= 35)) begin
                i_in_valid <= 1'b1;
                i_in <= pending_samples[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall; count out a requested hold-off here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_output && hold_count < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            i_out_stall <= !no_idle && $urandom_range(99) < 35;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result t=%0d p=%0d err=%0b",
                             o_out.temperature_tenths, o_out.pressure_pa, o_out.div_error);
            end else begin
                want = expected_readings.pop_front();
                if (o_out !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp t=%0d p=%0d err=%0b got t=%0d p=%0d err=%0b",
                                 want.temperature_tenths, want.pressure_pa, want.div_error,
                                 o_out.temperature_tenths, o_out.pressure_pa,
                                 o_out.div_error);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("barometric_pressure_compensation_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_AC123: cal_ac123 = val;
            CFG_AC456: cal_ac456 = val;
            CFG_B12:   cal_b12 = val[31:0];
            CFG_MCMD:  cal_mcmd = val[31:0];
            CFG_OSS:   cal_oss = val[1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !i_in_valid);
        wait (expected_readings.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_in rand_sample();
        t_in s;
        s.raw_temp = 16'($urandom);
        s.raw_pressure = 19'($urandom);
        if ($urandom_range(3) != 0) begin
            // realistic readings
            s.raw_temp = 16'($urandom_range(20000, 34000));
            s.raw_pressure = 19'($urandom_range(20000, 100000) << cal_oss);
        end
        return s;
    endfunction

    task automatic set_calibration(input int kind);
        case (kind)
            0: begin
                write_reg(CFG_AC123, {16'hC7B8, 16'hFFBA, 16'h0198});
                write_reg(CFG_AC456, {16'd23153, 16'd32757, 16'd32741});
                write_reg(CFG_B12, 48'({16'h002E, 16'h192E}));
                write_reg(CFG_MCMD, 48'({16'd2868, 16'hD4BD}));
            end
            1: begin
                write_reg(CFG_AC123, 48'hFFFF_FFFF_FFFF);
                write_reg(CFG_AC456, 48'hFFFF_FFFF_FFFF);
                write_reg(CFG_B12, 48'(32'hFFFF_FFFF));
                write_reg(CFG_MCMD, 48'(32'hFFFF_FFFF));
            end
            2: begin
                write_reg(CFG_AC123, {16'h7FFF, 16'h8000, 16'h8000});
                write_reg(CFG_AC456, {16'h0000, 16'h0001, 16'hFFFF});
                write_reg(CFG_B12, 48'({16'h7FFF, 16'h8000}));
                write_reg(CFG_MCMD, 48'({16'h0000, 16'h8000}));
            end
            default: begin
                write_reg(CFG_AC123, 48'({$urandom, $urandom}));
                write_reg(CFG_AC456, 48'({$urandom, $urandom}));
                write_reg(CFG_B12, 48'($urandom));
                write_reg(CFG_MCMD, 48'($urandom));
            end
        endcase
    endtask

    initial begin
        t_in s;
        no_idle = 1'b0;
        hold_output = 1'b0;
        pause_input = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_AC123;
        i_cfg_data = '0;
        cal_ac123 = '0; cal_ac456 = '0; cal_b12 = '0; cal_mcmd = '0; cal_oss = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: every divisor path hits zero
        pending_samples.push_back('{16'd0, 19'd0});
        pending_samples.push_back('{16'hFFFF, 19'h7FFFF});
        drain();

        // zero temperature divisor: ac5=0 and md=0 give x1+md == 0
        write_reg(CFG_AC456, {16'd1, 16'd0, 16'd1});
        pending_samples.push_back('{16'd100, 19'd5});
        // zero pressure divisor: ac4 = 0 with md nonzero
        drain();
        write_reg(CFG_MCMD, 48'({16'd1, 16'd7}));
        write_reg(CFG_AC456, {16'd0, 16'd0, 16'd0});
        pending_samples.push_back('{16'd1, 19'd1});
        drain();

        // directed extremes under each fixed calibration, oversampling 3 for the second, else 0
        for (int k = 0; k < 3; k++) begin
            set_calibration(k);
            write_reg(CFG_OSS, 48'(k == 1 ? 3 : 0));
            pending_samples.push_back('{16'd0, 19'd0});
            pending_samples.push_back('{16'hFFFF, 19'h7FFFF});
            pending_samples.push_back('{16'd27898, 19'd23843});
            pending_samples.push_back('{16'h8000, 19'h40000});
            pending_samples.push_back('{16'h7FFF, 19'h3FFFF});
            drain();
        end
        // negative divisor in the temperature division: md = -1, mc negative
        write_reg(CFG_AC456, {16'd0, 16'd0, 16'd1});
        write_reg(CFG_MCMD, 48'({16'hFFFF, 16'hF000}));
        pending_samples.push_back('{16'd0, 19'd12345});
        drain();

        // random phases across calibrations and oversampling settings
        for (int ph = 0; ph < 5; ph++) begin
            set_calibration(ph == 0 ? 0 : (ph == 4 ? 1 : 3));
            write_reg(CFG_OSS, 48'(ph % 4));
            write_reg(CFG_UNUSED, 48'hDEAD);   // unknown index is ignored
            no_idle = (ph == 2);
            for (int n = 0; n < N_RANDOM; n++) begin
                s = rand_sample();
                pending_samples.push_back(s);
            end
            if (ph == 1) begin
                // long receiver hold-off while input keeps coming
                hold_output = 1'b1;
                wait (hold_count == HOLD_CYCLES);
                hold_output = 1'b0;
            end
            if (ph == 3) begin
                // sender pause until fully drained
                repeat (60) @(posedge i_clk);
                pause_input = 1'b1;
                wait (expected_readings.size() == 0);
                @(posedge i_clk);
                pause_input = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("barometric_pressure_compensation_tb: PASS");
        else
            $display("barometric_pressure_compensation_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

/* barometric_pressure_compensation.f */
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_div.sv
rtl/bpc_press.sv
rtl/barometric_pressure_compensation.sv
test/barometric_pressure_compensation_tb.sv
